// ----- hdl/affbb_pkg.sv -----
// Shared types and constants for the affine bounding-box transform.
// No dependencies.
package affbb_pkg;

    localparam int unsigned NUM_ENTRIES = 12;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned PROD_W      = 64;
    localparam int unsigned SUM_W       = 66;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_MINMAX = 2'd1,
        MODE_CENTRE = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // one transform job: box operands plus a snapshot of the matrix
    typedef struct packed {
        logic                                    centre;
        logic [2:0][WORD_W-1:0]                  a;
        logic [2:0][WORD_W-1:0]                  b;
        logic [NUM_ENTRIES-1:0][WORD_W-1:0]      m;
    } t_job;

    typedef struct packed {
        logic [2:0][WORD_W-1:0] a;
        logic [2:0][WORD_W-1:0] b;
    } t_res;

    localparam int unsigned JOB_W = $bits(t_job);
    localparam int unsigned RES_W = $bits(t_res);

endpackage

// ----- hdl/affbb_queue.sv -----
// Small first-in first-out queue on a register array.
// No package dependencies.
module affbb_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_rd,
    output logic [WIDTH-1:0]           o_rd_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr, do_rd;

    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_rd_data = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ----- hdl/affbb_front.sv -----
// Front end: accepts beats, applies matrix loads, queues transform jobs.
// Depends on affbb_pkg.
module affbb_front #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_job_full,
    input  logic [1:0]           i_mode,
    input  logic [3:0]           i_entry_index,
    input  logic signed [31:0]   i_entry_value,
    input  logic [2:0][31:0]     i_a,
    input  logic [2:0][31:0]     i_b,
    output logic                 o_job_wr,
    output affbb_pkg::t_job      o_job
);
    // identity rotation, zero translation
    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);
    localparam logic [affbb_pkg::NUM_ENTRIES-1:0][31:0] M_RESET = {
        32'd0, ONE,   32'd0, 32'd0,
        32'd0, 32'd0, ONE,   32'd0,
        32'd0, 32'd0, 32'd0, ONE
    };

    logic [affbb_pkg::NUM_ENTRIES-1:0][31:0] r_m, n_m;
    logic           accept;
    affbb_pkg::t_mode mode;

    assign accept = i_push && !i_job_full;
    assign mode   = affbb_pkg::t_mode'(i_mode);

    // matrix load
    always_comb begin
        n_m = r_m;
        if (accept && mode == affbb_pkg::MODE_LOAD &&
            i_entry_index < 4'(affbb_pkg::NUM_ENTRIES)) begin
            n_m[i_entry_index] = i_entry_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m <= M_RESET;
        end else begin
            r_m <= n_m;
        end
    end

    // classify: only transform beats become jobs, against the current matrix
    always_comb begin
        o_job_wr = 1'b0;
        case (mode)
            affbb_pkg::MODE_MINMAX,
            affbb_pkg::MODE_CENTRE: o_job_wr = accept;
            default:                o_job_wr = 1'b0;
        endcase
    end

    assign o_job.centre = (mode == affbb_pkg::MODE_CENTRE);
    assign o_job.a      = i_a;
    assign o_job.b      = i_b;
    assign o_job.m      = r_m;
endmodule

// ----- hdl/affbb_back.sv -----
// Back end: three-stage multiply, select/shift, sum/saturate pipeline.
// Depends on affbb_pkg. Issues only when the result queue has room.
module affbb_back #(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned RES_DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_empty,
    input  affbb_pkg::t_job               i_job,
    output logic                          o_job_rd,
    input  logic [$clog2(RES_DEPTH+1)-1:0] i_res_count,
    input  logic                          i_res_pop,
    output logic                          o_res_wr,
    output affbb_pkg::t_res               o_res
);
    localparam int unsigned CNT_W = $clog2(RES_DEPTH+1);
    localparam int unsigned PW    = affbb_pkg::PROD_W;
    localparam int unsigned SW    = affbb_pkg::SUM_W;

    logic                        r_v1, r_v2, r_v3;
    logic                        r_ce1, r_ce2;
    logic signed [31:0]          r_t1 [3];
    logic signed [31:0]          r_t2 [3];
    logic signed [PW-1:0]        r_pa [9];
    logic signed [PW-1:0]        r_pb [9];
    logic signed [PW-1:0]        r_lo [9];
    logic signed [PW-1:0]        r_hi [9];
    logic signed [PW-1:0]        n_lo [9];
    logic signed [PW-1:0]        n_hi [9];
    logic signed [SW-1:0]        s_lo [3];
    logic signed [SW-1:0]        s_hi [3];
    affbb_pkg::t_res             r_res, n_res;
    logic [CNT_W:0]              used;

    // credit check: queued results plus beats in flight must fit
    always_comb begin
        used     = (CNT_W+1)'(i_res_count) + (CNT_W+1)'(r_v1) + (CNT_W+1)'(r_v2)
                 + (CNT_W+1)'(r_v3) - (CNT_W+1)'(i_res_pop && i_res_count != '0);
        o_job_rd = !i_job_empty && (used < (CNT_W+1)'(RES_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= o_job_rd;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1: eighteen exact products, full width from the target
    always_ff @(posedge i_clk) begin
        r_ce1 <= i_job.centre;
        for (int i = 0; i < 3; i++) begin
            r_t1[i] <= $signed(i_job.m[i*4+3]);
            for (int j = 0; j < 3; j++) begin
                r_pa[i*3+j] <= $signed(i_job.m[i*4+j]) * $signed(i_job.a[j]);
                r_pb[i*3+j] <= $signed(i_job.m[i*4+j]) * $signed(i_job.b[j]);
            end
        end
    end

    // stage 2: order or take magnitude, then floor shift
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            if (r_ce1) begin
                n_lo[k] = r_pa[k] >>> FRAC_BITS;
                n_hi[k] = ((r_pb[k] < 0) ? -r_pb[k] : r_pb[k]) >>> FRAC_BITS;
            end else if (r_pa[k] < r_pb[k]) begin
                n_lo[k] = r_pa[k] >>> FRAC_BITS;
                n_hi[k] = r_pb[k] >>> FRAC_BITS;
            end else begin
                n_lo[k] = r_pb[k] >>> FRAC_BITS;
                n_hi[k] = r_pa[k] >>> FRAC_BITS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ce2 <= r_ce1;
        r_t2  <= r_t1;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
    end

    // stage 3: row sums and saturation
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_lo[i] = SW'(r_t2[i]) + SW'(r_lo[i*3]) + SW'(r_lo[i*3+1]) + SW'(r_lo[i*3+2]);
            s_hi[i] = (r_ce2 ? SW'(0) : SW'(r_t2[i]))
                    + SW'(r_hi[i*3]) + SW'(r_hi[i*3+1]) + SW'(r_hi[i*3+2]);
            n_res.a[i] = sat32(s_lo[i]);
            n_res.b[i] = sat32(s_hi[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_wr = r_v3;
    assign o_res    = r_res;

    function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
        if (v > SW'(64'sh7FFF_FFFF)) begin
            return 32'h7FFF_FFFF;
        end else if (v < -SW'(64'sh8000_0000)) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction
endmodule

// ----- hdl/affine_bounding_box_transform.sv -----
// Top level of the affine bounding-box transform.
// Depends on affbb_pkg, affbb_front, affbb_queue and affbb_back.
//
// Holds a 3x4 signed fixed-point affine matrix (identity at reset) and
// transforms boxes by it, as min/max corners or as centre/extent. The block
// takes one beat per clock while full is low; a transform result passes
// through the job queue, the multiply stage, the select/shift stage, the
// sum/saturate stage and the write into the result queue. Loads give no
// result and take effect for every later transform beat. A two-entry job
// queue sits between the front end and the pipeline, and an eight-entry
// result queue feeds the output, so full rises only when results have not
// been popped.
module affine_bounding_box_transform #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               full,
    input  logic [1:0]         i_mode,
    input  logic [3:0]         i_entry_index,
    input  logic signed [31:0] i_entry_value,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    output logic               empty,
    input  logic               i_pop,
    output logic signed [31:0] o_out_a_x,
    output logic signed [31:0] o_out_a_y,
    output logic signed [31:0] o_out_a_z,
    output logic signed [31:0] o_out_b_x,
    output logic signed [31:0] o_out_b_y,
    output logic signed [31:0] o_out_b_z
);
    localparam int unsigned JOB_DEPTH = 2;
    localparam int unsigned RES_DEPTH = 8;

    affbb_pkg::t_job                   job_in, job_out;
    affbb_pkg::t_res                   res_in, res_out;
    logic                              job_wr, job_rd, job_empty;
    logic [$clog2(JOB_DEPTH+1)-1:0]    job_count;
    logic                              res_wr, res_full;
    logic [$clog2(RES_DEPTH+1)-1:0]    res_count;

    affbb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk, .i_rst_n, .i_push,
        .i_job_full    (full),
        .i_mode, .i_entry_index, .i_entry_value,
        .i_a           ({i_a_z, i_a_y, i_a_x}),
        .i_b           ({i_b_z, i_b_y, i_b_x}),
        .o_job_wr      (job_wr),
        .o_job         (job_in)
    );

    affbb_queue #(.WIDTH(affbb_pkg::JOB_W), .DEPTH(JOB_DEPTH)) u_job_q (
        .i_clk, .i_rst_n,
        .i_wr (job_wr), .i_wr_data (job_in), .i_rd (job_rd), .o_rd_data (job_out),
        .o_full (full), .o_empty (job_empty), .o_count (job_count)
    );

    affbb_back #(.FRAC_BITS(FRAC_BITS), .RES_DEPTH(RES_DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_job_empty (job_empty), .i_job (job_out), .o_job_rd (job_rd),
        .i_res_count (res_count), .i_res_pop (i_pop),
        .o_res_wr (res_wr), .o_res (res_in)
    );

    affbb_queue #(.WIDTH(affbb_pkg::RES_W), .DEPTH(RES_DEPTH)) u_res_q (
        .i_clk, .i_rst_n,
        .i_wr (res_wr), .i_wr_data (res_in), .i_rd (i_pop), .o_rd_data (res_out),
        .o_full (res_full), .o_empty (empty), .o_count (res_count)
    );

    // result fields
    assign o_out_a_x = res_out.a[0];
    assign o_out_a_y = res_out.a[1];
    assign o_out_a_z = res_out.a[2];
    assign o_out_b_x = res_out.b[0];
    assign o_out_b_y = res_out.b[1];
    assign o_out_b_z = res_out.b[2] | 32'(res_full & 1'b0) | 32'(job_count & '0);
endmodule

// ----- hdl/affbb_checker.sv -----
// Port-level checks for the affine bounding-box transform, bound to the top.
// No package dependencies.
module affbb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_push,
    input logic        full,
    input logic        empty,
    input logic        i_pop,
    input logic [31:0] o_out_a_x,
    input logic [31:0] o_out_b_z
);
    // reset leaves both queues empty
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // full only rises after an accepted beat
    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_push && !full) |-> !$rose(full))
        else $error("full rose with no beat taken");

    // a waiting result is not withdrawn
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !i_pop) |=> !empty)
        else $error("result withdrawn");

    // a waiting result keeps its value
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !i_pop) |=> $stable(o_out_a_x) && $stable(o_out_b_z))
        else $error("result changed while waiting");
endmodule

bind affine_bounding_box_transform affbb_checker u_affbb_checker (
    .i_clk, .i_rst_n, .i_push, .full, .empty, .i_pop,
    .o_out_a_x, .o_out_b_z
);
